@@ rtl/ordered_list_engine_assert.svh @@
// Assertion macros used by the list engine RTL.
// Each macro expects clk and arst_n to be visible where it is used.
`ifndef ORDERED_LIST_ENGINE_ASSERT_SVH
`define ORDERED_LIST_ENGINE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define OLIST_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("list engine check failed");

// The consequent must hold in the cycle after the antecedent.
`define OLIST_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("list engine check failed");

`endif

@@ rtl/olist_pkg.sv @@
package olist_pkg;

	localparam int CAPACITY_DEF = 16;

	localparam int REQ_TYPE_W = 3;
	localparam int POS_W      = 5;
	localparam int VALUE_W    = 8;
	localparam int FOUND_W    = 4;
	localparam int STATUS_W   = 2;
	localparam int COUNT_W    = 5;

	typedef enum logic [REQ_TYPE_W-1:0] {
		REQ_APPEND = 3'd0,
		REQ_INSERT = 3'd1,
		REQ_READ   = 3'd2,
		REQ_FIND   = 3'd3,
		REQ_DELETE = 3'd4,
		REQ_CLEAR  = 3'd5
	} req_code_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_RANGE = 2'd2,
		ST_MISS  = 2'd3
	} status_t;

	// Command broadcast to every cell of the chain.
	typedef struct packed {
		logic               shift_up;   // insert: value lands at pos, the tail moves up
		logic               shift_down; // delete: entries from pos on take the right neighbor
		logic               write_end;  // append: value lands at the current fill
		logic [POS_W-1:0]   pos;
		logic [VALUE_W-1:0] value;
	} cell_cmd_t;

endpackage

@@ rtl/olist_req_if.sv @@
interface olist_req_if;
	logic                               valid;
	logic                               ready;
	logic [olist_pkg::REQ_TYPE_W-1:0]   req_type;
	logic [olist_pkg::POS_W-1:0]        position;
	logic [olist_pkg::VALUE_W-1:0]      value;

	modport source (output valid, req_type, position, value, input ready);
	modport sink   (input valid, req_type, position, value, output ready);
endinterface

@@ rtl/olist_rsp_if.sv @@
interface olist_rsp_if;
	logic                             valid;
	logic                             ready;
	logic [olist_pkg::VALUE_W-1:0]    item;
	logic [olist_pkg::FOUND_W-1:0]    found_at;
	logic [olist_pkg::STATUS_W-1:0]   status;
	logic [olist_pkg::COUNT_W-1:0]    count;
	logic                             is_empty;

	modport source (output valid, item, found_at, status, count, is_empty, input ready);
	modport sink   (input valid, item, found_at, status, count, is_empty, output ready);
endinterface

@@ rtl/olist_cell.sv @@
module olist_cell #(
	parameter int CAPACITY = olist_pkg::CAPACITY_DEF,
	parameter int IDX      = 0
) (
	input  logic                                        clk,
	input  olist_pkg::cell_cmd_t                        cmd,
	input  logic [$clog2(CAPACITY+1)-1:0]               fill,
	input  logic [olist_pkg::VALUE_W-1:0]               left_data,
	input  logic [olist_pkg::VALUE_W-1:0]               right_data,
	output logic [olist_pkg::VALUE_W-1:0]               data,
	output logic                                        hit
);
	import olist_pkg::*;

	localparam int FW = $clog2(CAPACITY + 1);
	localparam int IW = (FW > POS_W) ? FW : POS_W;
	localparam logic [IW-1:0] MY_IDX = IW'(IDX);

	logic [VALUE_W-1:0] data_q;
	logic [IW-1:0]      pos_x;
	logic [IW-1:0]      fill_x;

	assign pos_x  = IW'(cmd.pos);
	assign fill_x = IW'(fill);

	always_ff @(posedge clk) begin
		if (cmd.shift_up) begin
			if (MY_IDX > pos_x) begin
				data_q <= left_data;
			end else if (MY_IDX == pos_x) begin
				data_q <= cmd.value;
			end
		end else if (cmd.shift_down) begin
			if (MY_IDX >= pos_x) begin
				data_q <= right_data;
			end
		end else if (cmd.write_end) begin
			if (MY_IDX == fill_x) begin
				data_q <= cmd.value;
			end
		end
	end

	assign data = data_q;
	assign hit  = (data_q == cmd.value) && (MY_IDX < fill_x);
endmodule

@@ rtl/olist_lowest.sv @@
module olist_lowest #(
	parameter int CAPACITY = olist_pkg::CAPACITY_DEF
) (
	input  logic [CAPACITY-1:0]             hits,
	output logic                            any,
	output logic [$clog2(CAPACITY)-1:0]     index
);
	localparam int XW = $clog2(CAPACITY);

	logic [CAPACITY-1:0] lowest;

	// Two's complement isolates the lowest set bit as a one-hot vector.
	assign lowest = hits & (~hits + CAPACITY'(1));
	assign any    = |hits;

	always_comb begin
		index = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (lowest[i]) begin
				index = index | XW'(i);
			end
		end
	end
endmodule

@@ rtl/ordered_list_engine.sv @@
// Ordered list of up to CAPACITY bytes held in a chain of cells, one byte per
// cell. A request is taken in every cycle in which the response register is
// empty or being drained, and its response appears in the cycle after it is
// taken, so the engine sustains one request per clock while responses drain.
// Insert shifts the cells above the position up, delete shifts those from the
// position on down, and find compares all cells at once before a lowest-index
// priority pick. Full lists and positions outside the list are refused with a
// status and leave the list untouched; a find that misses reports not found.
// Entries are never read at or beyond the count, so the cells need no reset.
module ordered_list_engine #(
	parameter int CAPACITY = olist_pkg::CAPACITY_DEF
) (
	input  logic         clk,
	input  logic         arst_n,
	olist_req_if.sink    req,
	olist_rsp_if.source  rsp
);
	import olist_pkg::*;

	`include "ordered_list_engine_assert.svh"

	localparam int FW = $clog2(CAPACITY + 1);
	localparam int IW = (FW > POS_W) ? FW : POS_W;
	localparam int XW = $clog2(CAPACITY);

	logic [FW-1:0]      fill_q;
	logic               rsp_valid_q;
	logic [VALUE_W-1:0] item_q;
	logic [FOUND_W-1:0] found_q;
	status_t            status_q;
	logic [COUNT_W-1:0] count_q;
	logic               empty_q;

	logic               accept;
	req_code_t          code;
	logic [IW-1:0]      pos_x;
	logic [IW-1:0]      fill_x;
	logic               full;
	logic [VALUE_W-1:0] sel_data;
	cell_cmd_t          cmd;
	logic [FW-1:0]      fill_next;
	logic [VALUE_W-1:0] item_next;
	logic [FOUND_W-1:0] found_next;
	status_t            status_next;

	logic [VALUE_W-1:0] cell_data [CAPACITY];
	logic [CAPACITY-1:0] hits;
	logic               any_hit;
	logic [XW-1:0]      hit_idx;

	assign req.ready = !rsp_valid_q || rsp.ready;
	assign accept    = req.valid && req.ready;
	assign code      = req_code_t'(req.req_type);
	assign pos_x     = IW'(req.position);
	assign fill_x    = IW'(fill_q);
	assign full      = (fill_q == FW'(CAPACITY));

	always_comb begin
		sel_data = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			if (IW'(i) == pos_x) begin
				sel_data = sel_data | cell_data[i];
			end
		end
	end

	// The cell command is built apart from the response so that the find
	// compare in the cells does not feed back into its own command.
	always_comb begin
		cmd.shift_up   = accept && (code == REQ_INSERT) && !full && (pos_x <= fill_x);
		cmd.shift_down = accept && (code == REQ_DELETE) && (pos_x < fill_x);
		cmd.write_end  = accept && (code == REQ_APPEND) && !full;
		cmd.pos        = req.position;
		cmd.value      = req.value;
	end

	always_comb begin
		fill_next      = fill_q;
		item_next      = '0;
		found_next     = '0;
		status_next    = ST_OK;
		unique case (code)
			REQ_APPEND: begin
				if (full) begin
					status_next = ST_FULL;
				end else begin
					fill_next     = fill_q + FW'(1);
				end
			end
			REQ_INSERT: begin
				if (full) begin
					status_next = ST_FULL;
				end else if (pos_x > fill_x) begin
					status_next = ST_RANGE;
				end else begin
					fill_next    = fill_q + FW'(1);
				end
			end
			REQ_READ: begin
				if (pos_x >= fill_x) begin
					status_next = ST_RANGE;
				end else begin
					item_next = sel_data;
				end
			end
			REQ_FIND: begin
				if (any_hit) begin
					found_next = FOUND_W'(hit_idx);
				end else begin
					status_next = ST_MISS;
				end
			end
			REQ_DELETE: begin
				if (pos_x >= fill_x) begin
					status_next = ST_RANGE;
				end else begin
					item_next      = sel_data;
					fill_next      = fill_q - FW'(1);
				end
			end
			REQ_CLEAR: begin
				fill_next = '0;
			end
			default: begin
			end
		endcase
	end

	for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
		logic [VALUE_W-1:0] left_d;
		logic [VALUE_W-1:0] right_d;

		if (g == 0) begin : g_first
			assign left_d = cell_data[g];
		end else begin : g_mid_l
			assign left_d = cell_data[g-1];
		end
		if (g == CAPACITY - 1) begin : g_last
			assign right_d = cell_data[g];
		end else begin : g_mid_r
			assign right_d = cell_data[g+1];
		end

		olist_cell #(
			.CAPACITY (CAPACITY),
			.IDX      (g)
		) u_cell (
			.clk        (clk),
			.cmd        (cmd),
			.fill       (fill_q),
			.left_data  (left_d),
			.right_data (right_d),
			.data       (cell_data[g]),
			.hit        (hits[g])
		);
	end

	olist_lowest #(
		.CAPACITY (CAPACITY)
	) u_lowest (
		.hits  (hits),
		.any   (any_hit),
		.index (hit_idx)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				fill_q      <= fill_next;
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q   <= item_next;
			found_q  <= found_next;
			status_q <= status_next;
			count_q  <= COUNT_W'(fill_next);
			empty_q  <= (fill_next == '0);
		end
	end

	assign rsp.valid    = rsp_valid_q;
	assign rsp.item     = item_q;
	assign rsp.found_at = found_q;
	assign rsp.status   = status_q;
	assign rsp.count    = count_q;
	assign rsp.is_empty = empty_q;

	// A request taken now must show up as a response in the next cycle.
	`OLIST_ASSERT_NEXT(a_accept_gives_rsp, accept, rsp_valid_q)
	// A stalled response must block new requests so that none is overwritten.
	`OLIST_ASSERT_SAME(a_stall_blocks, rsp_valid_q && !rsp.ready, !req.ready)
	// A full status is only reported while the list really is at capacity.
	`OLIST_ASSERT_SAME(a_full_matches, rsp_valid_q && (status_q == ST_FULL), full)
	// The empty flag of a pending response agrees with the stored count.
	`OLIST_ASSERT_SAME(a_empty_matches, rsp_valid_q, empty_q == (fill_q == '0))
endmodule
